// ----- design/rsa_pkg.sv -----
// rsa_pkg: shared types and constants for the running statistics accumulator
// item structs, operation codes, controller states and control/status bundles
// no dependencies
`timescale 1ns / 1ps

package rsa_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 24;
  localparam int FRAC_W   = 8;
  localparam int SUM_W    = SAMPLE_W + COUNT_W;
  localparam int SQ_W     = 2 * SAMPLE_W - 1 + COUNT_W;
  localparam int STAT_W   = SAMPLE_W + FRAC_W;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_MERGE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef struct packed {
    op_t                         op;
    logic signed [SAMPLE_W-1:0]  sample;
    logic        [COUNT_W-1:0]   merge_count;
    logic signed [SUM_W-1:0]     merge_sum;
    logic        [SQ_W-1:0]      merge_sumsq;
    logic signed [SAMPLE_W-1:0]  merge_min;
    logic signed [SAMPLE_W-1:0]  merge_max;
  } in_item_t;

  typedef struct packed {
    logic        [COUNT_W-1:0]   count;
    logic signed [SUM_W-1:0]     total;
    logic        [SQ_W-1:0]      total_sq;
    logic signed [SAMPLE_W-1:0]  min_value;
    logic signed [SAMPLE_W-1:0]  max_value;
    logic signed [STAT_W-1:0]    mean;
    logic        [STAT_W-1:0]    std_dev;
    logic        [STAT_W-1:0]    std_err;
    logic                        empty_res;
    logic                        dev_valid;
    logic                        saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_VAR,
    ST_VAR_WAIT,
    ST_SE_DIV,
    ST_SE_DIV_WAIT,
    ST_SE_SQRT,
    ST_SE_SQRT_WAIT,
    ST_OUT
  } ctl_state_t;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_VAR,
    DIV_SE
  } div_sel_t;

  typedef struct packed {
    logic apply;
    logic mean_go;
    logic var_go;
    logic se_go;
    logic sd_sqrt_go;
    logic se_sqrt_go;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic sqrt_busy;
    logic n_nz;
    logic n_ge2;
  } sts_t;

endpackage

// ----- design/rsa_datapath.sv -----
// rsa_datapath: accumulators, shift-add multiplier, restoring divider, square root
// and the output register
// depends on rsa_pkg
`timescale 1ns / 1ps

module rsa_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  rsa_pkg::in_item_t in_data,
  input  rsa_pkg::cmd_t     cmd,
  output rsa_pkg::sts_t     sts,
  output rsa_pkg::out_item_t out_data
);
  import rsa_pkg::*;

  localparam int PROD_W    = 80;
  localparam int DIV_W     = 96;
  localparam int DVS_W     = 48;
  localparam int ROOT_W    = 24;
  localparam int MUL_STEPS = 40;

  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [STAT_W-1:0] MEAN_POS = {1'b0, {(STAT_W-1){1'b1}}};
  localparam logic [STAT_W-1:0] MEAN_NEG = {1'b1, {(STAT_W-1){1'b0}}};
  localparam logic [STAT_W-1:0] STAT_SAT = {STAT_W{1'b1}};

  // accumulators
  logic        [COUNT_W-1:0]  cnt_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic        [SQ_W-1:0]     sq_r;
  logic signed [SAMPLE_W-1:0] lo_r, hi_r;
  logic                       ovf_r;

  logic signed [STAT_W-1:0] mean_r;
  logic [STAT_W-1:0]        sd_r, se_r;
  out_item_t                out_r;

  // update datapath
  logic signed [2*SAMPLE_W-1:0] smp_prod;
  logic [COUNT_W:0]             add_n, cnt_nxt;
  logic signed [SUM_W:0]        add_s, sum_nxt;
  logic [SQ_W:0]                add_q, sq_nxt;
  logic                         upd_ovf, ext_en;
  logic signed [SAMPLE_W-1:0]   ext_lo, ext_hi;
  logic [SUM_W-1:0]             smag;

  assign smp_prod = (2*SAMPLE_W)'(in_data.sample) * (2*SAMPLE_W)'(in_data.sample);
  assign smag     = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  always_comb begin
    if (in_data.op == OP_ADD) begin
      add_n  = (COUNT_W+1)'(1);
      add_s  = (SUM_W+1)'(in_data.sample);
      add_q  = (SQ_W+1)'(unsigned'(smp_prod));
      ext_en = 1'b1;
      ext_lo = in_data.sample;
      ext_hi = in_data.sample;
    end else begin
      add_n  = {1'b0, in_data.merge_count};
      add_s  = {in_data.merge_sum[SUM_W-1], in_data.merge_sum};
      add_q  = {1'b0, in_data.merge_sumsq};
      ext_en = (in_data.merge_count != '0);
      ext_lo = in_data.merge_min;
      ext_hi = in_data.merge_max;
    end
    cnt_nxt = {1'b0, cnt_r} + add_n;
    sum_nxt = {sum_r[SUM_W-1], sum_r} + add_s;
    sq_nxt  = {1'b0, sq_r} + add_q;
    upd_ovf = cnt_nxt[COUNT_W] | (sum_nxt[SUM_W] != sum_nxt[SUM_W-1]) | sq_nxt[SQ_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
      lo_r  <= SMP_MAX;
      hi_r  <= SMP_MIN;
      ovf_r <= 1'b0;
    end else if (cmd.apply) begin
      unique case (in_data.op)
        OP_ADD, OP_MERGE: begin
          if (upd_ovf) begin
            ovf_r <= 1'b1;
          end else begin
            cnt_r <= cnt_nxt[COUNT_W-1:0];
            sum_r <= sum_nxt[SUM_W-1:0];
            sq_r  <= sq_nxt[SQ_W-1:0];
            if (ext_en && ext_lo < lo_r) lo_r <= ext_lo;
            if (ext_en && ext_hi > hi_r) hi_r <= ext_hi;
          end
        end
        OP_CLEAR: begin
          cnt_r <= '0;
          sum_r <= '0;
          sq_r  <= '0;
          lo_r  <= SMP_MAX;
          hi_r  <= SMP_MIN;
          ovf_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // shift-add multiplier: n*sumsq and sum^2 side by side
  logic [PROD_W-1:0] mc_a_r, mc_b_r, acc_a_r, acc_b_r;
  logic [MUL_STEPS-1:0] mp_a_r, mp_b_r;
  logic [5:0]        mul_cnt_r;
  logic              mul_busy_r;
  logic [DVS_W-1:0]  nn1_r;
  logic [PROD_W-1:0] vdif;

  assign vdif = (acc_a_r >= acc_b_r) ? acc_a_r - acc_b_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_cnt_r  <= '0;
    end else if (cmd.mean_go) begin
      mul_busy_r <= 1'b1;
      mul_cnt_r  <= '0;
    end else if (mul_busy_r) begin
      mul_cnt_r <= mul_cnt_r + 6'd1;
      if (mul_cnt_r == 6'(MUL_STEPS - 1)) mul_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_go) begin
      mc_a_r  <= PROD_W'(sq_r);
      mp_a_r  <= MUL_STEPS'(cnt_r);
      mc_b_r  <= PROD_W'(smag);
      mp_b_r  <= smag;
      acc_a_r <= '0;
      acc_b_r <= '0;
      nn1_r   <= DVS_W'(cnt_r) * DVS_W'(cnt_r - COUNT_W'(1));
    end else if (mul_busy_r) begin
      if (mp_a_r[0]) acc_a_r <= acc_a_r + mc_a_r;
      if (mp_b_r[0]) acc_b_r <= acc_b_r + mc_b_r;
      mc_a_r <= mc_a_r << 1;
      mc_b_r <= mc_b_r << 1;
      mp_a_r <= mp_a_r >> 1;
      mp_b_r <= mp_b_r >> 1;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DVS_W-1:0]   rem_r, dvs_r;
  logic [DIV_W-1:0]   quo_r, var_q_r, se_q_r;
  logic [6:0]         div_cnt_r;
  logic               div_busy_r, div_fin_r;
  div_sel_t           div_sel_r;
  logic [DVS_W:0]     rem_sh;
  logic [DVS_W+1:0]   rem_dif;
  logic               q_bit;

  assign rem_sh  = {rem_r, quo_r[DIV_W-1]};
  assign rem_dif = {1'b0, rem_sh} - {2'b0, dvs_r};
  assign q_bit   = !rem_dif[DVS_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_fin_r  <= 1'b0;
      div_cnt_r  <= '0;
      div_sel_r  <= DIV_MEAN;
    end else begin
      div_fin_r <= 1'b0;
      if (cmd.mean_go || cmd.var_go || cmd.se_go) begin
        div_busy_r <= 1'b1;
        div_cnt_r  <= '0;
        div_sel_r  <= cmd.mean_go ? DIV_MEAN : (cmd.var_go ? DIV_VAR : DIV_SE);
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r + 7'd1;
        if (div_cnt_r == 7'(DIV_W - 1)) begin
          div_busy_r <= 1'b0;
          div_fin_r  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_go) begin
      quo_r <= DIV_W'({smag, {FRAC_W{1'b0}}});
      dvs_r <= DVS_W'(cnt_r);
      rem_r <= '0;
    end else if (cmd.var_go) begin
      quo_r <= {vdif, {(DIV_W-PROD_W){1'b0}}};
      dvs_r <= nn1_r;
      rem_r <= '0;
    end else if (cmd.se_go) begin
      quo_r <= var_q_r;
      dvs_r <= DVS_W'(cnt_r);
      rem_r <= '0;
    end else if (div_busy_r) begin
      rem_r <= q_bit ? rem_dif[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], q_bit};
    end
  end

  // digit-by-digit square root of a 48-bit value
  logic [2*ROOT_W-1:0] sq_src_r;
  logic [ROOT_W+1:0]   sq_rem_r;
  logic [ROOT_W-1:0]   sq_root_r;
  logic [4:0]          sq_cnt_r;
  logic                sq_busy_r, sq_fin_r, sq_sat_r, sq_sel_se_r;
  logic [ROOT_W+3:0]   sq_sh;
  logic [ROOT_W+4:0]   sq_dif;
  logic                r_bit;

  assign sq_sh  = {sq_rem_r, sq_src_r[2*ROOT_W-1 -: 2]};
  assign sq_dif = {1'b0, sq_sh} - {3'b0, sq_root_r, 2'b01};
  assign r_bit  = !sq_dif[ROOT_W+4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
      sq_fin_r  <= 1'b0;
      sq_cnt_r  <= '0;
    end else begin
      sq_fin_r <= 1'b0;
      if (cmd.sd_sqrt_go || cmd.se_sqrt_go) begin
        sq_busy_r <= 1'b1;
        sq_cnt_r  <= '0;
      end else if (sq_busy_r) begin
        sq_cnt_r <= sq_cnt_r + 5'd1;
        if (sq_cnt_r == 5'(ROOT_W - 1)) begin
          sq_busy_r <= 1'b0;
          sq_fin_r  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sd_sqrt_go || cmd.se_sqrt_go) begin
      sq_sel_se_r <= cmd.se_sqrt_go;
      sq_src_r    <= cmd.se_sqrt_go ? se_q_r[2*ROOT_W-1:0] : var_q_r[2*ROOT_W-1:0];
      // a root of more than 24 bits saturates
      sq_sat_r    <= cmd.se_sqrt_go ? (|se_q_r[DIV_W-1:2*ROOT_W])
                                    : (|var_q_r[DIV_W-1:2*ROOT_W]);
      sq_rem_r    <= '0;
      sq_root_r   <= '0;
    end else if (sq_busy_r) begin
      sq_rem_r  <= r_bit ? sq_dif[ROOT_W+1:0] : sq_sh[ROOT_W+1:0];
      sq_root_r <= {sq_root_r[ROOT_W-2:0], r_bit};
      sq_src_r  <= sq_src_r << 2;
    end
  end

  // statistic capture
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      mean_r <= '0;
      sd_r   <= '0;
      se_r   <= '0;
    end else begin
      if (div_fin_r) begin
        case (div_sel_r)
          DIV_MEAN: begin
            if (|quo_r[DIV_W-1:STAT_W-1]) mean_r <= sum_r[SUM_W-1] ? MEAN_NEG : MEAN_POS;
            else if (sum_r[SUM_W-1])      mean_r <= -quo_r[STAT_W-1:0];
            else                          mean_r <= quo_r[STAT_W-1:0];
          end
          DIV_VAR: var_q_r <= quo_r;
          default: se_q_r  <= quo_r;
        endcase
      end
      if (sq_fin_r) begin
        if (sq_sel_se_r) se_r <= sq_sat_r ? STAT_SAT : sq_root_r;
        else             sd_r <= sq_sat_r ? STAT_SAT : sq_root_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.count     <= cnt_r;
      out_r.total     <= sum_r;
      out_r.total_sq  <= sq_r;
      out_r.min_value <= lo_r;
      out_r.max_value <= hi_r;
      out_r.mean      <= mean_r;
      out_r.std_dev   <= sd_r;
      out_r.std_err   <= se_r;
      out_r.empty_res <= (cnt_r == '0);
      out_r.dev_valid <= (cnt_r >= COUNT_W'(2));
      out_r.saturated <= ovf_r;
    end
  end

  assign out_data      = out_r;
  assign sts.mul_busy  = mul_busy_r;
  assign sts.div_busy  = div_busy_r;
  assign sts.sqrt_busy = sq_busy_r;
  assign sts.n_nz      = (cnt_r != '0);
  assign sts.n_ge2     = (cnt_r >= COUNT_W'(2));

endmodule

// ----- design/rsa_ctrl.sv -----
// rsa_ctrl: sequencer for update, mean, variance and root steps, plus output valid
// depends on rsa_pkg
`timescale 1ns / 1ps

module rsa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  rsa_pkg::sts_t sts,
  output rsa_pkg::cmd_t cmd
);
  import rsa_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load)                 out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.apply = 1'b1;
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (sts.n_nz) begin
          cmd.mean_go = 1'b1;
          state_nxt   = ST_MEAN_WAIT;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_MEAN_WAIT: begin
        if (!sts.div_busy && !sts.mul_busy) state_nxt = sts.n_ge2 ? ST_VAR : ST_OUT;
      end
      ST_VAR: begin
        cmd.var_go = 1'b1;
        state_nxt  = ST_VAR_WAIT;
      end
      ST_VAR_WAIT: begin
        if (!sts.div_busy) state_nxt = ST_SE_DIV;
      end
      ST_SE_DIV: begin
        // variance over n runs in the divider while the root of the variance runs
        cmd.se_go      = 1'b1;
        cmd.sd_sqrt_go = 1'b1;
        state_nxt      = ST_SE_DIV_WAIT;
      end
      ST_SE_DIV_WAIT: begin
        if (!sts.div_busy && !sts.sqrt_busy) state_nxt = ST_SE_SQRT;
      end
      ST_SE_SQRT: begin
        cmd.se_sqrt_go = 1'b1;
        state_nxt      = ST_SE_SQRT_WAIT;
      end
      ST_SE_SQRT_WAIT: begin
        if (!sts.sqrt_busy) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/running_stats_accumulator.sv -----
// running_stats_accumulator: top level, controller plus datapath
// depends on rsa_pkg, rsa_ctrl, rsa_datapath
//
// Usage: each input transfer (in_valid high, in_stall low) carries one operation:
// add a sample, merge a partial summary, clear, or query. Every transfer yields
// exactly one result transfer on the out_ channel with count, sum, sum of squares,
// min, max, mean, standard deviation and standard error.
// Sequence: when the count is zero the result goes to the output register with no
// divider pass; with one sample only the mean pass runs. The input is taken one
// item at a time: a new item waits until the last result is written. With two or
// more samples the 96-step restoring divider runs three times (mean, variance,
// variance over count), with the 40-step multiplier hidden under the first pass
// and a 24-step root under the third, one more 24-step root after it.
// A new item is accepted while the previous result still waits in the output
// register; the block holds before writing the next result until that one is
// taken, and out_data stays stable while out_valid and out_stall are high.
// Reset (rst_n low, synchronous) empties the accumulators, clears the sticky
// overflow flag and drops out_valid.
`timescale 1ns / 1ps

module running_stats_accumulator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rsa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rsa_pkg::out_item_t out_data
);
  import rsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rsa_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ----- design/rsa_checker.sv -----
// rsa_checker: port-level assertions for running_stats_accumulator, bound to the top
// depends on rsa_pkg
`timescale 1ns / 1ps

module rsa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input rsa_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input rsa_pkg::out_item_t out_data
);
  import rsa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.empty_res == (out_data.count == '0)))
    else $error("empty flag disagrees with count");

  a_dev_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.dev_valid == (out_data.count >= COUNT_W'(2))))
    else $error("deviation flag disagrees with count");

  a_empty_stats: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_res |-> out_data.mean == '0)
    else $error("mean nonzero on empty summary");

  a_no_dev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.dev_valid |-> out_data.std_dev == '0 && out_data.std_err == '0)
    else $error("deviation nonzero with fewer than two samples");

endmodule

bind running_stats_accumulator rsa_checker u_rsa_checker (.*);
